// ===== rtl/core/bmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_pkg: shared types, constants and decoders for the bracket match checker
// Beat payload structs, sequencer states, cell opcodes, bracket decoding and
// penalty lookup.
// ----------------------------------------------------------------------------
package bmc_pkg;

    localparam int STACK_DEPTH_DEF = 256;

    // Line status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_CORRUPT  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    // Bracket characters
    localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
    localparam logic [7:0] CH_OPEN_ANGLE  = 8'h3C;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    // Bracket kinds
    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_in_line;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  line_status;
        logic [14:0] error_points;
        logic [63:0] completion_points;
        logic [31:0] total_error_points;
    } out_beat_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } bracket_t;

    function automatic bracket_t opener_decode(logic [7:0] c);
        bracket_t r;
        r.hit  = 1'b1;
        r.kind = KIND_PAREN;
        unique case (c)
            CH_OPEN_PAREN:  r.kind = KIND_PAREN;
            CH_OPEN_SQUARE: r.kind = KIND_SQUARE;
            CH_OPEN_CURLY:  r.kind = KIND_CURLY;
            CH_OPEN_ANGLE:  r.kind = KIND_ANGLE;
            default:        r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic bracket_t closer_decode(logic [7:0] c);
        bracket_t r;
        r.hit  = 1'b1;
        r.kind = KIND_PAREN;
        unique case (c)
            CH_CLOSE_PAREN:  r.kind = KIND_PAREN;
            CH_CLOSE_SQUARE: r.kind = KIND_SQUARE;
            CH_CLOSE_CURLY:  r.kind = KIND_CURLY;
            CH_CLOSE_ANGLE:  r.kind = KIND_ANGLE;
            default:         r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [14:0] penalty_of(logic [1:0] kind);
        logic [14:0] p;
        unique case (kind)
            KIND_PAREN:  p = 15'd3;
            KIND_SQUARE: p = 15'd57;
            KIND_CURLY:  p = 15'd1197;
            default:     p = 15'd25137;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bmc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_cell: one level of the shift-register bracket stack
// Holds one bracket kind. A push takes the kind from the level above, a pop
// takes the kind from the level below; otherwise the cell holds.
// ----------------------------------------------------------------------------
module bmc_cell (
    input  wire logic              clk,
    input  wire bmc_pkg::cell_ctrl_t ctrl,
    input  wire logic [1:0]        push_kind,
    input  wire logic [1:0]        pop_kind,
    output logic [1:0]             kind
);

    logic [1:0] kind_reg;
    logic [1:0] kind_next;

    // shift select
    always_comb
    begin
        unique case (ctrl.op)
            bmc_pkg::CELL_PUSH: kind_next = push_kind;
            bmc_pkg::CELL_POP:  kind_next = pop_kind;
            default:            kind_next = kind_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule
`default_nettype wire

// ===== rtl/core/bracket_match_checker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Timing: a character that does not end a line is handled as it is accepted, and a new beat
// can follow every cycle while idle. A line-end beat enters the drain state; on a good line it
// then pops one open level at a time to fold the completion score out of the top cell, and
// finally loads the result register once the previous result has been taken (out_ready).
// Throughput: 1 character per cycle inside a line; in_ready stays low for the line-end cycles.
// Reset: rst_n (async, active low) clears depth, flags, penalties, handshakes; cells keep data.
// ----------------------------------------------------------------------------
// bracket_match_checker_top: bracket matching over a chain of stack cells
// Pushes openers into a shift-register stack, checks closers against the top
// level, tracks penalties and folds the completion score at line end.
// ----------------------------------------------------------------------------
module bracket_match_checker_top #(
    parameter int STACK_DEPTH = bmc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bmc_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bmc_pkg::out_beat_t      out_data
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

    bmc_pkg::state_t   state_reg, state_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [1:0]        bad_reg, bad_next;
    logic [14:0]       pen_reg, pen_next;
    logic [31:0]       total_reg, total_next;
    logic [63:0]       comp_reg, comp_next;
    logic              out_valid_reg, out_valid_next;
    bmc_pkg::out_beat_t out_data_reg, out_data_next;

    bmc_pkg::cell_ctrl_t cell_ctrl;
    logic [1:0]          push_kind;
    logic [1:0]          kind_w [STACK_DEPTH];

    bmc_pkg::bracket_t opener;
    bmc_pkg::bracket_t closer;
    logic              accept;
    logic              slot_free;

    // stack cell chain, level 0 is the top
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [1:0] from_above;
        logic [1:0] from_below;
        if (i == 0)
        begin : g_top
            assign from_above = push_kind;
        end
        else
        begin : g_mid
            assign from_above = kind_w[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign from_below = bmc_pkg::KIND_PAREN;
        end
        else
        begin : g_up
            assign from_below = kind_w[i+1];
        end
        bmc_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .push_kind (from_above),
            .pop_kind  (from_below),
            .kind      (kind_w[i])
        );
    end

    assign opener    = bmc_pkg::opener_decode(in_data.char_code);
    assign closer    = bmc_pkg::closer_decode(in_data.char_code);
    assign in_ready  = (state_reg == bmc_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign push_kind = opener.kind;

    // sequencer: character handling, score fold and result load
    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        bad_next       = bad_reg;
        pen_next       = pen_reg;
        total_next     = total_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        cell_ctrl.op   = bmc_pkg::CELL_HOLD;

        unique case (state_reg)
            bmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (bad_reg == bmc_pkg::STAT_OK)
                    begin
                        if (opener.hit)
                        begin
                            if (depth_reg == DEPTH_FULL)
                            begin
                                bad_next = bmc_pkg::STAT_OVERFLOW;
                            end
                            else
                            begin
                                cell_ctrl.op = bmc_pkg::CELL_PUSH;
                                depth_next   = depth_reg + 1'b1;
                            end
                        end
                        else if (closer.hit)
                        begin
                            if (depth_reg == '0 || kind_w[0] != closer.kind)
                            begin
                                bad_next   = bmc_pkg::STAT_CORRUPT;
                                pen_next   = bmc_pkg::penalty_of(closer.kind);
                                total_next = total_reg
                                           + {17'd0, bmc_pkg::penalty_of(closer.kind)};
                            end
                            else
                            begin
                                cell_ctrl.op = bmc_pkg::CELL_POP;
                                depth_next   = depth_reg - 1'b1;
                            end
                        end
                    end
                    if (in_data.last_in_line)
                    begin
                        comp_next  = '0;
                        state_next = bmc_pkg::ST_DRAIN;
                    end
                end
            end
            bmc_pkg::ST_DRAIN:
            begin
                if (bad_reg == bmc_pkg::STAT_OK && depth_reg != '0)
                begin
                    // fold one level: score * 5 + value
                    cell_ctrl.op = bmc_pkg::CELL_POP;
                    depth_next   = depth_reg - 1'b1;
                    comp_next    = {comp_reg[61:0], 2'b00} + comp_reg
                                 + {62'd0, kind_w[0]} + 64'd1;
                end
                else if (slot_free)
                begin
                    out_valid_next                   = 1'b1;
                    out_data_next.line_status        = bad_reg;
                    out_data_next.error_points       = pen_reg;
                    out_data_next.completion_points  = comp_reg;
                    out_data_next.total_error_points = total_reg;
                    depth_next                       = '0;
                    bad_next                         = bmc_pkg::STAT_OK;
                    pen_next                         = '0;
                    state_next                       = bmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmc_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmc_pkg::ST_IDLE;
            depth_reg     <= '0;
            bad_reg       <= bmc_pkg::STAT_OK;
            pen_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            bad_reg       <= bad_next;
            pen_reg       <= pen_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        comp_reg     <= comp_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    // depth counter never passes the number of cells
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_FULL)
        else $error("stack depth beyond cell count");

    // a good line drains one level per cycle
    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmc_pkg::ST_DRAIN && bad_reg == bmc_pkg::STAT_OK && depth_reg != '0)
        |=> (depth_reg == $past(depth_reg) - 1'b1))
        else $error("drain did not pop one level");

    // a bad line reports no completion score
    a_bad_no_score: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.line_status != bmc_pkg::STAT_OK)
        |-> (out_data.completion_points == 64'd0))
        else $error("completion score on bad line");

    // overflow carries no penalty
    a_overflow_no_pen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.line_status == bmc_pkg::STAT_OVERFLOW)
        |-> (out_data.error_points == 15'd0))
        else $error("penalty on overflow line");
`endif

endmodule
`default_nettype wire

// ===== bench/bracket_match_checker_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_match_checker_top_test: self-checking bench for the bracket matcher
// Sends character beats line by line and keeps its own bracket stack for each
// line. Every line-end beat yields one predicted result. Each result beat is
// checked field by field against the oldest prediction. Both handshakes stall
// at random.
// ----------------------------------------------------------------------------
module bracket_match_checker_top_test;
    import bmc_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int ITEM_TARGET  = 750;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = DEPTH + 40;
    localparam int PRINT_CAP    = 40;

    // Penalty of each closing bracket kind
    localparam logic [14:0] PTS_PAREN  = 15'd3;
    localparam logic [14:0] PTS_SQUARE = 15'd57;
    localparam logic [14:0] PTS_CURLY  = 15'd1197;
    localparam logic [14:0] PTS_ANGLE  = 15'd25137;

    typedef enum int {
        LN_BALANCED,
        LN_INCOMPLETE,
        LN_CORRUPT,
        LN_EMPTY_CLOSE,
        LN_NOISE,
        LN_FULL,
        LN_OVERFLOW
    } line_kind_t;

    // Line predictor plus the queue of line results still owed by the block
    class bracket_scoreboard;
        logic [1:0]   open_kind [DEPTH];
        int unsigned  depth = 0;
        logic [1:0]   line_state = STAT_OK;
        logic [14:0]  line_pts = '0;
        logic [31:0]  pts_total = '0;
        out_beat_t    pending_lines [$];
        int unsigned  mismatches = 0;
        int unsigned  lines_seen = 0;
        int unsigned  status_seen [3] = '{0, 0, 0};

        // 1 when ch is a bracket; tells its direction and kind
        function bit classify(input logic [7:0] ch, output bit is_open,
                              output logic [1:0] kind);
            is_open = 1'b1;
            kind    = KIND_PAREN;
            case (ch)
                CH_OPEN_PAREN:   kind = KIND_PAREN;
                CH_OPEN_SQUARE:  kind = KIND_SQUARE;
                CH_OPEN_CURLY:   kind = KIND_CURLY;
                CH_OPEN_ANGLE:   kind = KIND_ANGLE;
                CH_CLOSE_PAREN:  begin is_open = 1'b0; kind = KIND_PAREN;  end
                CH_CLOSE_SQUARE: begin is_open = 1'b0; kind = KIND_SQUARE; end
                CH_CLOSE_CURLY:  begin is_open = 1'b0; kind = KIND_CURLY;  end
                CH_CLOSE_ANGLE:  begin is_open = 1'b0; kind = KIND_ANGLE;  end
                default:         return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function logic [14:0] points_of(input logic [1:0] kind);
            case (kind)
                KIND_PAREN:  return PTS_PAREN;
                KIND_SQUARE: return PTS_SQUARE;
                KIND_CURLY:  return PTS_CURLY;
                default:     return PTS_ANGLE;
            endcase
        endfunction

        // Apply one accepted character beat; a line end queues its result
        function void take_char(input in_beat_t beat);
            bit          is_open;
            logic [1:0]  kind;
            logic [63:0] score;
            out_beat_t   res;
            if (line_state == STAT_OK && classify(beat.char_code, is_open, kind)) begin
                if (is_open) begin
                    if (depth >= DEPTH)
                        line_state = STAT_OVERFLOW;
                    else begin
                        open_kind[depth] = kind;
                        depth++;
                    end
                end
                else if (depth == 0 || open_kind[depth - 1] != kind) begin
                    line_state = STAT_CORRUPT;
                    line_pts   = points_of(kind);
                    pts_total  = pts_total + 32'(points_of(kind));
                end
                else
                    depth--;
            end
            if (beat.last_in_line) begin
                // completion score folds from the top of the stack down
                score = '0;
                if (line_state == STAT_OK)
                    for (int lvl = int'(depth) - 1; lvl >= 0; lvl--)
                        score = score * 64'd5 + 64'(open_kind[lvl]) + 64'd1;
                res.line_status        = line_state;
                res.error_points       = line_pts;
                res.completion_points  = score;
                res.total_error_points = pts_total;
                pending_lines.push_back(res);
                depth      = 0;
                line_state = STAT_OK;
                line_pts   = '0;
            end
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        // Compare one accepted result beat with the oldest pending line
        task check_line(input out_beat_t got);
            out_beat_t want;
            if (pending_lines.size() == 0) begin
                report("result beat with no line pending");
                return;
            end
            want = pending_lines.pop_front();
            lines_seen++;
            status_seen[int'(want.line_status)]++;
            if (got.line_status !== want.line_status)
                report($sformatf("line %0d status %0d, want %0d", lines_seen,
                                 got.line_status, want.line_status));
            if (got.error_points !== want.error_points)
                report($sformatf("line %0d error points %0d, want %0d", lines_seen,
                                 got.error_points, want.error_points));
            if (got.completion_points !== want.completion_points)
                report($sformatf("line %0d completion %h, want %h", lines_seen,
                                 got.completion_points, want.completion_points));
            if (got.total_error_points !== want.total_error_points)
                report($sformatf("line %0d total points %0d, want %0d", lines_seen,
                                 got.total_error_points, want.total_error_points));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_beat_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_beat_t  out_data;

    bracket_scoreboard sb = new;
    logic [7:0]  line_buf [$];
    int unsigned idle_cycles = 0;
    int unsigned sent_beats = 0;
    int unsigned rand_items = 0;
    int unsigned deep_lines = 0;
    int          burst_left = 0;

    bracket_match_checker_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Bracket characters by kind
    function automatic logic [7:0] open_char(input logic [1:0] k);
        case (k)
            KIND_PAREN:  return CH_OPEN_PAREN;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            KIND_CURLY:  return CH_OPEN_CURLY;
            default:     return CH_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input logic [1:0] k);
        case (k)
            KIND_PAREN:  return CH_CLOSE_PAREN;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            KIND_CURLY:  return CH_CLOSE_CURLY;
            default:     return CH_CLOSE_ANGLE;
        endcase
    endfunction

    function automatic logic [1:0] rand_kind();
        return 2'($urandom_range(0, 3));
    endfunction

    // a byte that is not a bracket
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c inside {CH_OPEN_PAREN, CH_OPEN_SQUARE, CH_OPEN_CURLY, CH_OPEN_ANGLE,
                         CH_CLOSE_PAREN, CH_CLOSE_SQUARE, CH_CLOSE_CURLY, CH_CLOSE_ANGLE});
        return c;
    endfunction

    // any byte, brackets made common
    function automatic logic [7:0] any_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        return ($urandom_range(0, 1) == 0) ? open_char(rand_kind()) : close_char(rand_kind());
    endfunction

    // Hand one beat over; between bursts the sender drops valid for a while
    task automatic send_char(input logic [7:0] ch, input logic last);
        in_beat_t beat;
        int       gap;
        beat.char_code    = ch;
        beat.last_in_line = last;
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        sent_beats++;
        if (burst_left > 0)
            burst_left--;
        else begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_buf();
        foreach (line_buf[i])
            send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    // Build one line of the given shape into line_buf
    task automatic build_line(input line_kind_t kind);
        logic [1:0] open_q [$];
        logic [1:0] k;
        int         len;
        line_buf.delete();
        case (kind)
            LN_FULL, LN_OVERFLOW:
            begin
                repeat (DEPTH) line_buf.push_back(open_char(rand_kind()));
                if (kind == LN_OVERFLOW) begin
                    line_buf.push_back(open_char(rand_kind()));
                    repeat ($urandom_range(0, 6)) line_buf.push_back(any_char());
                end
            end
            LN_NOISE:
                repeat ($urandom_range(1, 12)) line_buf.push_back(any_char());
            default:
            begin
                // nested prefix with matched pops and some filler
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        line_buf.push_back(noise_char());
                    else if (open_q.size() > 0 && $urandom_range(0, 2) == 0)
                        line_buf.push_back(close_char(open_q.pop_back()));
                    else begin
                        k = rand_kind();
                        open_q.push_back(k);
                        line_buf.push_back(open_char(k));
                    end
                end
                case (kind)
                    LN_BALANCED:
                        while (open_q.size() > 0)
                            line_buf.push_back(close_char(open_q.pop_back()));
                    LN_CORRUPT:
                    begin
                        // wrong closer for the top, or any closer on an empty stack
                        k = (open_q.size() == 0) ? rand_kind()
                                                 : open_q[$] ^ 2'($urandom_range(1, 3));
                        line_buf.push_back(close_char(k));
                        repeat ($urandom_range(0, 8)) line_buf.push_back(any_char());
                    end
                    LN_EMPTY_CLOSE:
                    begin
                        while (open_q.size() > 0)
                            line_buf.push_back(close_char(open_q.pop_back()));
                        line_buf.push_back(close_char(rand_kind()));
                        repeat ($urandom_range(0, 6)) line_buf.push_back(any_char());
                    end
                    default:;
                endcase
            end
        endcase
    endtask

    // Receiver: switches between always ready, light and heavy stalling
    always @(posedge clk)
    begin
        static int ready_mode = 0;
        static int ready_left = 0;
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(20, 200);
        end
        else
            ready_left--;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Monitor: accepted beats feed the predictor and the checker
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.take_char(in_data);
            if (out_valid && out_ready)
                sb.check_line(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any beat
    initial
    begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin
        line_kind_t pick;
        int         roll;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: matched pair, open line, close on empty, each penalty,
        // beats after a fault, byte extremes, full nest
        send_text("()");
        send_text("[<{(");
        send_text(")");
        send_text("(]}>");
        send_text("<}");
        send_text("[>");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("([{<>}])");

        // a stack filled to the brim, then one past it
        build_line(LN_FULL);
        send_buf();
        build_line(LN_OVERFLOW);
        send_buf();
        deep_lines += 2;

        // random lines, mostly well formed in shape, until the beat budget is spent
        while (sent_beats < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 30)      pick = LN_BALANCED;
            else if (roll < 55) pick = LN_INCOMPLETE;
            else if (roll < 75) pick = LN_CORRUPT;
            else if (roll < 85) pick = LN_EMPTY_CLOSE;
            else if (roll < 98) pick = LN_NOISE;
            else if (roll < 99) pick = LN_FULL;
            else                pick = LN_OVERFLOW;
            // a deep line only while it still fits the budget
            if ((pick == LN_FULL || pick == LN_OVERFLOW)
                && sent_beats + DEPTH + 8 > ITEM_TARGET)
                pick = LN_BALANCED;
            build_line(pick);
            send_buf();
            if (pick == LN_FULL || pick == LN_OVERFLOW)
                deep_lines++;
            else
                rand_items += line_buf.size();
        end
        in_valid <= 1'b0;

        while (sb.pending_lines.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d lines: %0d clean or open, %0d corrupt, %0d overflowed",
                 sb.lines_seen, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
        $display("%0d character beats sent, %0d in random short lines, %0d full-depth lines",
                 sent_beats, rand_items, deep_lines);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== bracket_match_checker_top.f =====
rtl/core/bmc_pkg.sv
rtl/core/bmc_cell.sv
rtl/core/bracket_match_checker_top.sv
bench/bracket_match_checker_top_test.sv
